// ===== hw/rtl/scaled_row_scatter_accumulate_assert.svh =====
// ----------------------------------------------------------------------------
// scaled_row_scatter_accumulate assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALED_ROW_SCATTER_ACCUMULATE_ASSERT_SVH
`define SCALED_ROW_SCATTER_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define SRSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srsa_pkg.sv =====
// ----------------------------------------------------------------------------
// srsa_pkg
// shared types and constants of the scaled row scatter-accumulate block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srsa_pkg;

  // target matrix geometry
  localparam int ROWS    = 256;
  localparam int COLS    = 16;
  localparam int ENTRIES = ROWS * COLS;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BND_W   = 17;

  // field widths
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int ROWF_W  = 16;
  localparam int COLF_W  = 4;
  localparam int TROWS_W = 9;

  // configuration port
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_TROWS = 2'd2;

  localparam logic [DATA_W-1:0]  ALPHA_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0]  BETA_RST  = 32'h0000_0000;
  localparam logic [TROWS_W-1:0] TROWS_RST = 9'd256;

  // item operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN   = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_SCATTER = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  // configuration register set
  typedef struct packed {
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic [TROWS_W-1:0]       target_rows;
  } cfg_t;

endpackage

// ===== hw/rtl/srsa_if.sv =====
// ----------------------------------------------------------------------------
// srsa_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srsa_in_if;
  import srsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [ROWF_W-1:0]        row;
  logic [COLF_W-1:0]        col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, func, row, col, value, input ready);
  modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface srsa_out_if;
  import srsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic                     row_err;

  modport source (output valid, data, row_err, input ready);
  modport sink   (input valid, data, row_err, output ready);
endinterface

// ===== hw/rtl/srsa_ram.sv =====
// ----------------------------------------------------------------------------
// srsa_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/srsa_cfg.sv =====
// ----------------------------------------------------------------------------
// srsa_cfg
// APB-style register file for alpha, beta and target_rows
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srsa_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srsa_pkg::CFG_AW-1:0]  paddr,
  input  logic [srsa_pkg::CFG_DW-1:0]  pwdata,
  output logic [srsa_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output srsa_pkg::cfg_t               cfg
);
  import srsa_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha       <= ALPHA_RST;
      cfg_r.beta        <= BETA_RST;
      cfg_r.target_rows <= TROWS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALPHA: cfg_r.alpha       <= pwdata;
        REG_BETA:  cfg_r.beta        <= pwdata;
        REG_TROWS: cfg_r.target_rows <= pwdata[TROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ALPHA: prdata = cfg_r.alpha;
      REG_BETA:  prdata = cfg_r.beta;
      REG_TROWS: prdata = CFG_DW'(cfg_r.target_rows);
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/scaled_row_scatter_accumulate.sv =====
// ----------------------------------------------------------------------------
// scaled_row_scatter_accumulate
// sequence: the item is taken and its read issued in S_IDLE, the read data
//   and beta product are captured in S_MUL, write-back and result reg follow
//   in S_WB, which waits only while the previous result waits in the output reg
// items: the next item is taken only after write-back of the last, set by the
//   single read-modify-write sequence through the target and touched-mask memories
// reset: control, error flag and per-row touched valid bits clear synchronously;
//   target memory contents stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scaled_row_scatter_accumulate_assert.svh"

module scaled_row_scatter_accumulate (
  input  logic                         clk,
  input  logic                         rst_n,
  srsa_in_if.sink                      in_ch,
  srsa_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [srsa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [srsa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [srsa_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import srsa_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W - 16 + 1;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_WB} state_t;

  // entry address of a row/column pair
  function automatic logic [ENT_W-1:0] ent_of(input logic [ROWF_W-1:0] r,
                                              input logic [COLF_W-1:0] c);
    ent_of = ENT_W'(32'(ROW_W'(r)) * COLS + 32'(COL_IW'(c)));
  endfunction

  // row and column fall within the store
  function automatic logic in_store(input logic [ROWF_W-1:0] r,
                                    input logic [COLF_W-1:0] c);
    in_store = (32'(r) < ROWS) && (32'(c) < COLS);
  endfunction

  cfg_t cfg;

  state_t                    state_r;
  logic                      err_r;
  logic                      out_vld_r;
  logic [DATA_W-1:0]         out_data_r;
  logic                      out_err_r;
  logic [ROWS-1:0]           row_vld_r;

  func_t                     item_func_r;
  logic [ROWF_W-1:0]         item_row_r;
  logic [COLF_W-1:0]         item_col_r;
  logic [DATA_W-1:0]         item_value_r;
  logic signed [PROD_W-1:0]  prod_a_r;
  logic signed [PROD_W-1:0]  prod_b_r;
  logic [DATA_W-1:0]         old_r;
  logic [COLS-1:0]           mrow_r;

  logic                      in_acc;
  logic                      wb_go;
  logic signed [DATA_W-1:0]  alpha_s;
  logic signed [DATA_W-1:0]  beta_s;
  logic signed [DATA_W-1:0]  value_s;
  logic signed [DATA_W-1:0]  old_s;
  logic signed [PROD_W-1:0]  prod_a_nxt;
  logic signed [PROD_W-1:0]  prod_b_nxt;

  logic [DATA_W-1:0]         tgt_rdata;
  logic [COLS-1:0]           mask_rdata;
  logic                      tgt_we;
  logic [DATA_W-1:0]         tgt_wdata;
  logic                      mask_we;
  logic [COLS-1:0]           mask_wdata;

  logic [ROW_W-1:0]          item_ridx;
  logic [COL_IW-1:0]         item_cidx;
  logic                      item_inside;
  logic [BND_W-1:0]          bound;
  logic                      row_ok;
  logic                      scat;
  logic                      set_err;
  logic                      do_upd;
  logic                      touched;
  logic [SUM_W-1:0]          addend;
  logic [SUM_W-1:0]          sum;
  logic [DATA_W-1:0]         sat;
  logic [COLS-1:0]           col_bit;
  logic                      err_nxt;
  logic [DATA_W-1:0]         res_data;

  // configuration registers
  srsa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // target entries, one word each
  srsa_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (ent_of(item_row_r, item_col_r)),
    .wdata (tgt_wdata),
    .re    (in_acc),
    .raddr (ent_of(in_ch.row, in_ch.col)),
    .rdata (tgt_rdata)
  );

  // touched mask, one row of bits per word
  srsa_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (item_ridx),
    .wdata (mask_wdata),
    .re    (in_acc),
    .raddr (ROW_W'(in_ch.row)),
    .rdata (mask_rdata)
  );

  // handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wb_go       = (state_r == S_WB) && (!out_vld_r || out_ch.ready);

  assign out_ch.valid   = out_vld_r;
  assign out_ch.data    = out_data_r;
  assign out_ch.row_err = out_err_r;

  // multipliers: alpha*value at the transaction, beta*old after the read
  assign alpha_s    = cfg.alpha;
  assign beta_s     = cfg.beta;
  assign value_s    = in_ch.value;
  assign old_s      = tgt_rdata;
  assign prod_a_nxt = alpha_s * value_s;
  assign prod_b_nxt = beta_s * old_s;

  // write-back decisions and saturating sum
  always_comb begin
    item_ridx   = ROW_W'(item_row_r);
    item_cidx   = COL_IW'(item_col_r);
    item_inside = in_store(item_row_r, item_col_r);

    if (BND_W'(cfg.target_rows) < BND_W'(ROWS)) begin
      bound = BND_W'(cfg.target_rows);
    end else begin
      bound = BND_W'(ROWS);
    end
    row_ok  = BND_W'(item_row_r) < bound;
    scat    = (item_func_r == FUNC_SCATTER) && !err_r;
    set_err = scat && !row_ok;
    do_upd  = scat && row_ok && (32'(item_col_r) < COLS);

    // a first touch with zero beta ignores the old entry entirely
    touched = mrow_r[item_cidx];
    if (touched) begin
      addend = {{(SUM_W - DATA_W){old_r[DATA_W-1]}}, old_r};
    end else if (cfg.beta == '0) begin
      addend = '0;
    end else begin
      addend = {prod_b_r[PROD_W-1], prod_b_r[PROD_W-1:16]};
    end
    sum = {prod_a_r[PROD_W-1], prod_a_r[PROD_W-1:16]} + addend;

    if ((&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1])) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end

    col_bit            = '0;
    col_bit[item_cidx] = 1'b1;

    tgt_we     = wb_go && (((item_func_r == FUNC_WRITE) && item_inside) || do_upd);
    tgt_wdata  = (item_func_r == FUNC_WRITE) ? item_value_r : sat;
    mask_we    = wb_go && do_upd;
    mask_wdata = mrow_r | col_bit;

    if (item_func_r == FUNC_BEGIN) begin
      err_nxt = 1'b0;
    end else begin
      err_nxt = err_r || set_err;
    end

    if ((item_func_r == FUNC_READ) && item_inside) begin
      res_data = old_r;
    end else if (do_upd) begin
      res_data = sat;
    end else begin
      res_data = '0;
    end
  end

  // sequencer, flags, row valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
      out_err_r <= 1'b0;
      row_vld_r <= '0;
    end else begin
      // result valid: set on write-back, cleared when taken
      if (wb_go) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            state_r    <= S_IDLE;
            err_r      <= err_nxt;
            out_data_r <= res_data;
            out_err_r  <= err_nxt;
            if (item_func_r == FUNC_BEGIN) begin
              row_vld_r <= '0;
            end else if (do_upd) begin
              row_vld_r[item_ridx] <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_func_r  <= func_t'(in_ch.func);
      item_row_r   <= in_ch.row;
      item_col_r   <= in_ch.col;
      item_value_r <= in_ch.value;
      prod_a_r     <= prod_a_nxt;
    end
    if (state_r == S_MUL) begin
      old_r    <= tgt_rdata;
      prod_b_r <= prod_b_nxt;
      // rows untouched since the last begin read as all clear
      mrow_r   <= row_vld_r[item_ridx] ? mask_rdata : '0;
    end
  end

  // checks
  `SRSA_ASSERT_NXT(a_acc_to_mul, in_acc, state_r == S_MUL, "transaction did not start the read")
  `SRSA_ASSERT_NXT(a_wb_hold, (state_r == S_WB) && out_vld_r && !out_ch.ready, (state_r == S_WB) && out_vld_r, "write-back overran a pending result")
  `SRSA_ASSERT_IMP(a_we_in_wb, tgt_we || mask_we, state_r == S_WB, "memory write outside write-back")
  `SRSA_ASSERT_IMP(a_err_rise, $rose(err_r), ($past(item_func_r) == FUNC_SCATTER) && ($past(state_r) == S_WB), "error flag set by a non-scatter item")
  `SRSA_ASSERT_NXT(a_err_out, wb_go, out_ch.row_err == err_r, "result flag differs from sticky flag")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for scaled_row_scatter_accumulate
// Drives begin, write, scatter and read transactions through the item channel
// and compares every result against a cycle-free prediction of the target
// matrix, touched bits and sticky row error. Register settings change
// between phases while the block is idle. Both channel sides idle at random,
// and one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import srsa_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 96;
  localparam int RECENT_DEPTH = 8;
  localparam int REPORT_LIMIT = 10;
  localparam longint SAT_MAX  = 64'sd2147483647;
  localparam longint SAT_MIN  = -SAT_MAX - 1;

  typedef struct {
    func_t                    func;
    logic [ROWF_W-1:0]        row;
    logic [COLF_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic                     row_err;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  srsa_in_if  in_if ();
  srsa_out_if out_if ();

  scaled_row_scatter_accumulate dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // traffic state
  item_t       pending_items[$];
  result_t     awaited_results[$];
  int unsigned recent_entries[$];
  int unsigned items_generated;
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        in_took;
  logic        press_go;
  logic        rx_hold;

  // predicted block state
  logic [DATA_W-1:0]        shadow_store [ENTRIES];
  bit                       shadow_touched [ENTRIES];
  bit                       shadow_error;
  logic signed [DATA_W-1:0] cur_alpha;
  logic signed [DATA_W-1:0] cur_beta;
  logic [TROWS_W-1:0]       cur_trows;

  // clock
  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  function automatic void note_mismatch(string msg);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endfunction

  function automatic int unsigned active_rows();
    return (cur_trows < ROWS) ? int'(cur_trows) : ROWS;
  endfunction

  // q16.16 product, floor of the exact product
  function automatic longint q_product(logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  // apply one transaction to the shadow matrix and return its result
  function automatic result_t apply_to_matrix(item_t it);
    result_t     r;
    bit          in_store;
    int unsigned idx;
    longint      acc;
    r.data   = '0;
    in_store = (it.row < ROWS) && (it.col < COLS);
    idx      = in_store ? it.row * COLS + it.col : 0;
    case (it.func)
      FUNC_BEGIN: begin
        foreach (shadow_touched[i]) shadow_touched[i] = 1'b0;
        shadow_error = 1'b0;
      end
      FUNC_WRITE: begin
        if (in_store) shadow_store[idx] = it.value;
      end
      FUNC_READ: begin
        if (in_store) r.data = shadow_store[idx];
      end
      FUNC_SCATTER: begin
        if (!shadow_error) begin
          if (it.row >= active_rows()) begin
            shadow_error = 1'b1;
          end else if (it.col < COLS) begin
            acc = q_product(cur_alpha, it.value);
            if (shadow_touched[idx]) acc += longint'($signed(shadow_store[idx]));
            else acc += q_product(cur_beta, shadow_store[idx]);
            if (acc > SAT_MAX) acc = SAT_MAX;
            if (acc < SAT_MIN) acc = SAT_MIN;
            r.data              = acc[DATA_W-1:0];
            shadow_store[idx]   = r.data;
            shadow_touched[idx] = 1'b1;
          end
        end
      end
    endcase
    r.row_err = shadow_error;
    return r;
  endfunction

  // item driver
  always @(negedge clk) begin : item_driver
    item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_items.pop_front();
        in_if.valid <= 1'b1;
        in_if.func  <= nxt.func;
        in_if.row   <= nxt.row;
        in_if.col   <= nxt.col;
        in_if.value <= nxt.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    rx_hold = 1'b0;
    wait (press_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // transaction monitor: predict on input, compare on output
  always @(posedge clk) begin : result_check
    item_t   seen;
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen.func  = func_t'(in_if.func);
        seen.row   = in_if.row;
        seen.col   = in_if.col;
        seen.value = in_if.value;
        awaited_results.push_back(apply_to_matrix(seen));
      end
      if (out_if.valid && out_if.ready) begin
        got.data    = out_if.data;
        got.row_err = out_if.row_err;
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result data %h row_err %b",
                                  got.data, got.row_err));
        end else begin
          want = awaited_results.pop_front();
          if (got.data !== want.data) begin
            note_mismatch($sformatf("data expected %h actual %h", want.data, got.data));
          end
          if (got.row_err !== want.row_err) begin
            note_mismatch($sformatf("row_err expected %b actual %b",
                                    want.row_err, got.row_err));
          end
        end
      end
    end
  end

  // apb register write, setup then access
  task automatic write_register(logic [1:0] reg_index, logic [CFG_DW-1:0] wdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_index)
      REG_ALPHA: cur_alpha = wdata;
      REG_BETA:  cur_beta  = wdata;
      REG_TROWS: cur_trows = wdata[TROWS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] alpha, logic [31:0] beta, int unsigned trows);
    write_register(REG_ALPHA, alpha);
    write_register(REG_BETA, beta);
    write_register(REG_TROWS, trows);
  endtask

  // wait until every transaction has gone through and the pipeline is empty
  task automatic settle();
    while (pending_items.size() != 0 || in_if.valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(func_t f, int unsigned row, int unsigned col, logic [31:0] v);
    item_t it;
    it.func  = f;
    it.row   = ROWF_W'(row);
    it.col   = COLF_W'(col);
    it.value = v;
    pending_items.push_back(it);
    items_generated++;
    if (f == FUNC_WRITE && it.row < ROWS) begin
      recent_entries.push_back(it.row * COLS + it.col);
      if (recent_entries.size() > RECENT_DEPTH) void'(recent_entries.pop_front());
    end
  endtask

  // mostly wide random, some extremes and small magnitudes
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3: begin
        v = $urandom_range(32'h0007_FFFF);
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // entry known to hold data, optionally one that passes the row check
  function automatic bit find_loaded(bit need_row_ok, output int unsigned idx);
    int unsigned cands[$];
    idx = 0;
    foreach (recent_entries[i]) begin
      if (!need_row_ok || recent_entries[i] / COLS < active_rows()) begin
        cands.push_back(recent_entries[i]);
      end
    end
    if (cands.size() == 0) return 1'b0;
    idx = cands[$urandom_range(cands.size() - 1)];
    return 1'b1;
  endfunction

  task automatic gen_window_write(int unsigned base_row, int unsigned win_rows,
                                  int unsigned base_col);
    push_item(FUNC_WRITE, base_row + $urandom_range(win_rows - 1),
              (base_col + $urandom_range(1)) % COLS, pick_value());
  endtask

  // in-range scatter; a scaled first touch only lands on loaded entries
  task automatic gen_scatter(int unsigned base_row, int unsigned win_rows,
                             int unsigned base_col);
    int unsigned idx;
    if (cur_beta != 0 || $urandom_range(99) < 60) begin
      if (!find_loaded(1'b1, idx)) begin
        gen_window_write(base_row, win_rows, base_col);
        void'(find_loaded(1'b1, idx));
      end
      push_item(FUNC_SCATTER, idx / COLS, idx % COLS, pick_value());
    end else begin
      push_item(FUNC_SCATTER, base_row + $urandom_range(win_rows - 1),
                (base_col + $urandom_range(1)) % COLS, pick_value());
    end
  endtask

  task automatic gen_bad_scatter();
    if (active_rows() < ROWS && $urandom_range(1)) begin
      push_item(FUNC_SCATTER, $urandom_range(ROWS - 1, active_rows()),
                $urandom_range(COLS - 1), pick_value());
    end else begin
      push_item(FUNC_SCATTER, $urandom_range(65535, ROWS), $urandom_range(COLS - 1),
                pick_value());
    end
  endtask

  task automatic gen_read();
    int unsigned idx;
    if ($urandom_range(99) >= 15 && find_loaded(1'b0, idx)) begin
      push_item(FUNC_READ, idx / COLS, idx % COLS, $urandom());
    end else begin
      push_item(FUNC_READ, $urandom_range(65535, ROWS), $urandom_range(COLS - 1), $urandom());
    end
  endtask

  // one accumulation pass: begin (mostly), load a small window, then scatter into it among reads and writes
  task automatic gen_frame();
    int unsigned win_rows;
    int unsigned base_row;
    int unsigned base_col;
    int unsigned pick;
    win_rows = (active_rows() < 4) ? active_rows() : 4;
    base_row = $urandom_range(active_rows() - win_rows);
    base_col = $urandom_range(COLS - 1);
    // occasionally skip the begin to carry touched bits and the flag over
    if ($urandom_range(19) != 0) push_item(FUNC_BEGIN, $urandom(), $urandom(), $urandom());
    repeat ($urandom_range(2, 5)) gen_window_write(base_row, win_rows, base_col);
    repeat ($urandom_range(6, 14)) begin
      pick = $urandom_range(99);
      if (pick < 62) gen_scatter(base_row, win_rows, base_col);
      else if (pick < 80) gen_read();
      else if (pick < 92) gen_window_write(base_row, win_rows, base_col);
      else if (pick < 96) gen_bad_scatter();
      else push_item(FUNC_WRITE, $urandom_range(65535), $urandom_range(COLS - 1), $urandom());
    end
    if ($urandom_range(99) < 35) begin
      gen_bad_scatter();
      gen_scatter(base_row, win_rows, base_col);
      repeat ($urandom_range(1, 2)) gen_read();
    end
  endtask

  // main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    in_if.valid     = 1'b0;
    in_if.func      = FUNC_BEGIN;
    in_if.row       = '0;
    in_if.col       = '0;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
    press_go        = 1'b0;
    tx_idle_pct     = 29;
    rx_idle_pct     = 81;
    mismatch_count  = 0;
    items_generated = 0;
    cur_alpha       = ALPHA_RST;
    cur_beta        = BETA_RST;
    cur_trows       = TROWS_RST;
    shadow_error    = 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    foreach (shadow_touched[i]) shadow_touched[i] = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at reset settings
    push_item(FUNC_BEGIN, 0, 0, 0);
    push_item(FUNC_WRITE, 0, 0, 32'h7FFF_FFFF);
    push_item(FUNC_WRITE, ROWS - 1, COLS - 1, 32'h8000_0000);
    push_item(FUNC_READ, 0, 0, 0);
    push_item(FUNC_READ, ROWS - 1, COLS - 1, 0);
    // first touch, then back-to-back positive saturation
    push_item(FUNC_SCATTER, 0, 0, 32'h0001_0000);
    push_item(FUNC_SCATTER, 0, 0, 32'h7FFF_FFFF);
    // negative extremes and negative saturation
    push_item(FUNC_SCATTER, ROWS - 1, COLS - 1, 32'h8000_0000);
    push_item(FUNC_SCATTER, ROWS - 1, COLS - 1, 32'hFFFF_FFFF);
    push_item(FUNC_READ, 0, 0, 0);
    // accesses outside the store, then a write and two scatters at row 1
    push_item(FUNC_WRITE, ROWS, 3, 32'h0000_0001);
    push_item(FUNC_READ, 16'hFFFF, COLS - 1, 0);
    push_item(FUNC_WRITE, 1, 1, 32'h0000_0005);
    push_item(FUNC_SCATTER, 1, 1, 32'h0002_0000);
    push_item(FUNC_SCATTER, 1, 1, 32'hFFFF_8000);
    // row error, then scatter while flagged
    push_item(FUNC_SCATTER, ROWS, 0, 32'h0001_0000);
    push_item(FUNC_SCATTER, 0, 0, 32'h0000_0001);
    push_item(FUNC_READ, 1, 1, 0);
    push_item(FUNC_WRITE, 0, 0, 32'h0000_0000);
    push_item(FUNC_READ, 0, 0, 0);
    // begin clears flag and touched bits
    push_item(FUNC_BEGIN, 16'hFFFF, COLS - 1, 32'hFFFF_FFFF);
    push_item(FUNC_SCATTER, 0, 0, 32'hFFFF_FFFF);
    push_item(FUNC_SCATTER, 0, 0, 32'hFFFF_FFFF);
    push_item(FUNC_SCATTER, 16'hFFFF, 0, 32'h0000_0001);
    settle();

    // random phases over several register settings
    for (int phase = 1; phase <= 6; phase++) begin
      if (phase <= 2) begin
        tx_idle_pct = 29;
        rx_idle_pct = 81;
      end else if (phase <= 4) begin
        tx_idle_pct = 81;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        1: apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 1);
        2: apply_settings($urandom(), $urandom(), $urandom_range(2, ROWS - 1));
        3: apply_settings(32'h8000_0000, 32'h7FFF_FFFF, ROWS);
        4: apply_settings(32'h0001_0000, 32'hFFFF_0000, 17);
        5: apply_settings({{14{1'b0}}, 18'($urandom())}, 32'h0000_0000, ROWS);
        default: apply_settings(32'h0000_0000, 32'h0000_8000, ROWS);
      endcase
      items_generated = 0;
      while (items_generated < PHASE_ITEMS) gen_frame();
      if (phase == 5) press_go = 1'b1;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/srsa_pkg.sv
hw/rtl/srsa_if.sv
hw/rtl/srsa_ram.sv
hw/rtl/srsa_cfg.sv
hw/rtl/scaled_row_scatter_accumulate.sv
dv/testbench.sv
